// ===== design/six_face_orientation_hysteresis_core_macros.svh =====
// assertion macros for the six-face orientation core
// no dependencies; included by files that carry concurrent assertions
`ifndef SIX_FACE_ORIENTATION_HYSTERESIS_CORE_MACROS_SVH
`define SIX_FACE_ORIENTATION_HYSTERESIS_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SFOH_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfoh: same-cycle check failed");

// next-cycle implication, checked outside reset
`define SFOH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfoh: next-cycle check failed");

`endif

// ===== design/sfoh_pkg.sv =====
// package for the six-face orientation core: widths, codes, reset values
// and the window / match functions; no dependencies
package sfoh_pkg;

  localparam int ACCEL_W   = 16;
  localparam int CFG_W     = 14;
  localparam int FACE_W    = 3;
  localparam int CALC_W    = 18;   // holds |+-g - a| up to 49151 signed
  localparam int CFG_IDX_W = 1;
  localparam int S_DATA_W  = 48;   // three axes, already whole bytes
  localparam int M_DATA_W  = 8;    // face padded to one byte

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_G    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd1;

  localparam logic [CFG_W-1:0] UNIT_G_RST    = 14'd4096;
  localparam logic [CFG_W-1:0] THRESHOLD_RST = 14'd1638;

  // face codes
  localparam logic [FACE_W-1:0] FACE_UNKNOWN = 3'd0;
  localparam logic [FACE_W-1:0] FACE_NX      = 3'd1;
  localparam logic [FACE_W-1:0] FACE_PZ      = 3'd2;
  localparam logic [FACE_W-1:0] FACE_PY      = 3'd3;
  localparam logic [FACE_W-1:0] FACE_NY      = 3'd4;
  localparam logic [FACE_W-1:0] FACE_NZ      = 3'd5;
  localparam logic [FACE_W-1:0] FACE_PX      = 3'd6;
  localparam int NUM_FACES = 6;

  // axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // unit vector component codes
  localparam logic signed [1:0] COMP_NEG  = 2'sb11;
  localparam logic signed [1:0] COMP_ZERO = 2'sb00;
  localparam logic signed [1:0] COMP_POS  = 2'sb01;

  typedef logic signed [CALC_W-1:0] calc_t;

  // component of a face's unit vector along one axis; unknown is zero
  function automatic logic signed [1:0] face_comp(input logic [FACE_W-1:0] face,
                                                  input logic [1:0] axis);
    logic signed [1:0] c;
    c = COMP_ZERO;
    case (face)
      FACE_NX: if (axis == AXIS_X) c = COMP_NEG;
      FACE_PZ: if (axis == AXIS_Z) c = COMP_POS;
      FACE_PY: if (axis == AXIS_Y) c = COMP_POS;
      FACE_NY: if (axis == AXIS_Y) c = COMP_NEG;
      FACE_NZ: if (axis == AXIS_Z) c = COMP_NEG;
      FACE_PX: if (axis == AXIS_X) c = COMP_POS;
      default: c = COMP_ZERO;
    endcase
    return c;
  endfunction

  // axis value leaves the hysteresis window of component c
  function automatic logic axis_out(input logic signed [1:0] c, input calc_t a,
                                    input calc_t g, input calc_t t);
    logic o;
    case (c)
      COMP_POS: o = (a < g - t);
      COMP_NEG: o = (a > t - g);
      default:  o = (a < -t) || (a > t);
    endcase
    return o;
  endfunction

  // |c*g - a| < lim
  function automatic logic axis_hit(input logic signed [1:0] c, input calc_t a,
                                    input calc_t g, input calc_t lim);
    calc_t v;
    calc_t d;
    calc_t m;
    case (c)
      COMP_POS: v = g;
      COMP_NEG: v = -g;
      default:  v = '0;
    endcase
    d = v - a;
    m = (d < 0) ? -d : d;
    return (m < lim);
  endfunction

endpackage

// ===== design/six_face_orientation_hysteresis_core.sv =====
// six-face orientation detector with hysteresis, top level
// depends on sfoh_pkg and six_face_orientation_hysteresis_core_macros.svh
//
// usage:
//   s_* channel takes one acceleration sample per item (x, y, z signed counts,
//   unit_g counts per g). m_* channel returns one item per sample: the face
//   after that sample (0 unknown, 1 -X, 2 +Z, 3 +Y, 4 -Y, 5 -Z, 6 +X).
//   cfg_we / cfg_index / cfg_data write unit_g (index 0) and threshold
//   (index 1); write them only while no item is in flight.
// timing:
//   an accepted sample lands in the input register; once the result slot is
//   free or draining, the window check and six face matches run on it and
//   load the result register and the stored face together, raising m_tvalid.
//   throughput is 1 item per cycle while m_tready stays high.
// reset:
//   rst (synchronous, active high) clears both stages, sets the face to
//   unknown and loads unit_g = 4096, threshold = 1638.
// back-pressure:
//   while m_tready is low behind a shown result, both registers hold and
//   s_tready drops once the input register is full; no item is lost.
`include "six_face_orientation_hysteresis_core_macros.svh"

module six_face_orientation_hysteresis_core (
  input  logic                          clk,
  input  logic                          rst,
  // sample in
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [sfoh_pkg::S_DATA_W-1:0] s_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
  // face out
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [sfoh_pkg::M_DATA_W-1:0] m_tdata,   // face[2:0], zero[7:3]
  // configuration writes
  input  logic                          cfg_we,
  input  logic [sfoh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfoh_pkg::CFG_W-1:0]    cfg_data
);
  import sfoh_pkg::*;

  // configuration
  logic [CFG_W-1:0] unit_g;
  logic [CFG_W-1:0] threshold;

  // input stage
  logic                      in_valid;
  logic signed [ACCEL_W-1:0] in_x;
  logic signed [ACCEL_W-1:0] in_y;
  logic signed [ACCEL_W-1:0] in_z;

  // result stage and state
  logic              out_valid;
  logic [FACE_W-1:0] out_face;
  logic [FACE_W-1:0] cur_face;

  logic              s_accept;
  logic              advance;
  logic              leave;
  logic              any_hit;
  logic [FACE_W-1:0] hit_face;
  logic [FACE_W-1:0] cur_face_next;
  calc_t             g_ext;
  calc_t             t_ext;
  calc_t             lim;
  calc_t             a_ext [3];

  // input stage moves on when the result slot is free or being drained
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_g    <= UNIT_G_RST;
      threshold <= THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UNIT_G:    unit_g    <= cfg_data;
        REG_THRESHOLD: threshold <= cfg_data;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_x <= $signed(s_tdata[ACCEL_W-1:0]);
      in_y <= $signed(s_tdata[2*ACCEL_W-1:ACCEL_W]);
      in_z <= $signed(s_tdata[3*ACCEL_W-1:2*ACCEL_W]);
    end
  end

  // widen everything to the common signed compare width
  assign g_ext    = $signed({{(CALC_W-CFG_W){1'b0}}, unit_g});
  assign t_ext    = $signed({{(CALC_W-CFG_W){1'b0}}, threshold});
  assign lim      = g_ext - t_ext;
  assign a_ext[0] = $signed({{(CALC_W-ACCEL_W){in_x[ACCEL_W-1]}}, in_x});
  assign a_ext[1] = $signed({{(CALC_W-ACCEL_W){in_y[ACCEL_W-1]}}, in_y});
  assign a_ext[2] = $signed({{(CALC_W-ACCEL_W){in_z[ACCEL_W-1]}}, in_z});

  // hold check against the current face, then first matching face wins
  always_comb begin
    logic hit;
    leave = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (axis_out(face_comp(cur_face, 2'(k)), a_ext[k], g_ext, t_ext)) begin
        leave = 1'b1;
      end
    end
    any_hit  = 1'b0;
    hit_face = FACE_UNKNOWN;
    // walk from the top so the lowest face number takes priority
    for (int f = NUM_FACES; f >= 1; f--) begin
      hit = 1'b1;
      for (int k = 0; k < 3; k++) begin
        if (!axis_hit(face_comp(FACE_W'(f), 2'(k)), a_ext[k], g_ext, lim)) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        any_hit  = 1'b1;
        hit_face = FACE_W'(f);
      end
    end
    cur_face_next = (leave && any_hit) ? hit_face : cur_face;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_face  <= FACE_UNKNOWN;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        cur_face  <= cur_face_next;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_face <= cur_face_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_DATA_W-FACE_W){1'b0}}, out_face};

  // a shown result always matches the stored face
  `SFOH_ASSERT_NOW(a_out_tracks_state, clk, rst, out_valid, out_face == cur_face)
  // a committed sample always produces a result
  `SFOH_ASSERT_NEXT(a_commit_gives_result, clk, rst, advance, out_valid)
  // inside the window the face holds
  `SFOH_ASSERT_NEXT(a_hold_in_window, clk, rst, advance && !leave, cur_face == $past(cur_face))
  // stored face never leaves the legal code range
  `SFOH_ASSERT_NOW(a_face_range, clk, rst, 1'b1, cur_face <= FACE_PX)

endmodule

// ===== sim/tb.sv =====
// self-checking bench for six_face_orientation_hysteresis_core: directed table, then random
// samples over several unit_g / threshold settings, checked against typed faces or a model
// depends on sfoh_pkg and the core rtl only
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfoh_pkg::*;

  localparam int PHASE_ITEMS = 200;   // random items per register setting
  localparam int STALL_LIMIT = 1000;  // cycles with no accept on either side
  localparam int PRINT_CAP   = 50;    // mismatch lines printed at most
  localparam int DRAIN_WAIT  = 4;     // extra settling cycles after the owed faces have come back

  // one directed row: sample and, where obvious, the face it must give
  typedef struct {
    int                x;
    int                y;
    int                z;
    bit                typed;
    logic [FACE_W-1:0] face;
  } sample_row_t;

  // one register setting for a random phase
  typedef struct {
    int g;
    int t;
  } cal_point_t;

  // face owed by the block, with the sample number for messages
  typedef struct {
    logic [FACE_W-1:0] face;
    int                seq;
  } face_due_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [S_DATA_W-1:0]    s_tdata;   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
  logic                   m_tvalid;
  logic                   m_tready;
  logic [M_DATA_W-1:0]    m_tdata;   // face[2:0], zero[7:3]
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  // local copy of the block's registers and stored face
  int                unit_g_q;
  int                thresh_q;
  logic [FACE_W-1:0] held_face;

  face_due_t   faces_due[$];
  int          face_errors;
  int          sample_seq;
  int          quiet_cycles;
  bit          steady;             // no idling on either side while set

  sample_row_t directed_rows[19];
  cal_point_t  cal_points[10];

  six_face_orientation_hysteresis_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // unit vector component of a face along one axis, unknown is all zero
  function automatic int face_dir(input logic [FACE_W-1:0] face, input int axis);
    case (face)
      FACE_NX: return (axis == AXIS_X) ? -1 : 0;
      FACE_PX: return (axis == AXIS_X) ?  1 : 0;
      FACE_NY: return (axis == AXIS_Y) ? -1 : 0;
      FACE_PY: return (axis == AXIS_Y) ?  1 : 0;
      FACE_NZ: return (axis == AXIS_Z) ? -1 : 0;
      FACE_PZ: return (axis == AXIS_Z) ?  1 : 0;
      default: return 0;
    endcase
  endfunction

  // face after one sample: hold while inside the held face's window,
  // otherwise first face (1..6) within g - t on every axis, else keep
  function automatic logic [FACE_W-1:0] predict_face(input logic [FACE_W-1:0] held,
                                                     input logic signed [15:0] ax,
                                                     input logic signed [15:0] ay,
                                                     input logic signed [15:0] az);
    int   a[3];
    int   lim;
    int   c;
    int   d;
    bit   leave;
    bit   hit;
    a[0] = ax;
    a[1] = ay;
    a[2] = az;
    lim = unit_g_q - thresh_q;
    leave = 1'b0;
    for (int k = 0; k < 3; k++) begin
      c = face_dir(held, k);
      if (c == 0)
        leave |= (a[k] < -thresh_q) || (a[k] > thresh_q);
      else if (c > 0)
        leave |= (a[k] < lim);
      else
        leave |= (a[k] > -lim);
    end
    if (!leave)
      return held;
    for (int f = FACE_NX; f <= FACE_PX; f++) begin
      hit = 1'b1;
      for (int k = 0; k < 3; k++) begin
        d = face_dir(f[FACE_W-1:0], k) * unit_g_q - a[k];
        if (d < 0)
          d = -d;
        if (!(d < lim))
          hit = 1'b0;
      end
      if (hit)
        return f[FACE_W-1:0];
    end
    return held;
  endfunction

  // one axis value around component c of a face: noise scaled to the
  // current window, exact window edges, or anything at all
  function automatic logic signed [15:0] axis_sample(input int c);
    int base;
    int lim;
    int span;
    int v;
    base = c * unit_g_q;
    lim = unit_g_q - thresh_q;
    span = 0;
    case ($urandom_range(0, 5))
      0, 1: span = thresh_q + 1;
      2:    span = ((lim < 0) ? -lim : lim) + 1;
      3:    span = unit_g_q + 1;
      4: begin
        // right on the hold window and the match limit
        if (c == 0) begin
          case ($urandom_range(0, 3))
            0:       v = thresh_q;
            1:       v = -thresh_q;
            2:       v = thresh_q + 1;
            default: v = -thresh_q - 1;
          endcase
        end else begin
          case ($urandom_range(0, 5))
            0:       v = base - lim;
            1:       v = base + lim;
            2:       v = base - lim + 1;
            3:       v = base + lim - 1;
            4:       v = c * lim;
            default: v = c * lim - c;
          endcase
        end
      end
      default: return 16'($urandom);
    endcase
    if (span > 0)
      v = base + int'($urandom_range(0, 2 * span)) - span;
    if (v > 32767)
      v = 32767;
    if (v < -32768)
      v = -32768;
    return 16'(v);
  endfunction

  task automatic report_mismatch(input string what);
    if (face_errors < PRINT_CAP)
      $display("%0t: mismatch: %s", $realtime, what);
    face_errors++;
  endtask

  // offer one sample, wait for the handshake, then book the face it owes
  task automatic send_sample(input logic signed [15:0] ax, input logic signed [15:0] ay,
                             input logic signed [15:0] az, input bit typed,
                             input logic [FACE_W-1:0] typed_face);
    logic [FACE_W-1:0] next;
    face_due_t         due;
    while (!steady && $urandom_range(0, 99) < 7) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {az, ay, ax};
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    next = predict_face(held_face, ax, ay, az);
    held_face = next;
    due.face = typed ? typed_face : next;
    due.seq  = sample_seq;
    faces_due.push_back(due);
    sample_seq++;
    @(negedge clk);
  endtask

  // stop offering and wait until every owed face has come back
  task automatic drain;
    s_tvalid <= 1'b0;
    while (faces_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // write both registers, block idle
  task automatic load_cal(input int g, input int t);
    cfg_we    <= 1'b1;
    cfg_index <= REG_UNIT_G;
    cfg_data  <= CFG_W'(g);
    @(negedge clk);
    cfg_index <= REG_THRESHOLD;
    cfg_data  <= CFG_W'(t);
    @(negedge clk);
    cfg_we    <= 1'b0;
    unit_g_q = g & 16'h3fff;
    thresh_q = t & 16'h3fff;
  endtask

  // result side: compare every accepted face with the oldest one owed
  always @(posedge clk) begin : face_monitor
    face_due_t due;
    if (!rst && m_tvalid && m_tready) begin
      if (faces_due.size() == 0) begin
        report_mismatch($sformatf("face %0d with no sample pending", m_tdata[FACE_W-1:0]));
      end else begin
        due = faces_due.pop_front();
        if (m_tdata[FACE_W-1:0] !== due.face)
          report_mismatch($sformatf("sample %0d: face %0d, want %0d",
                                    due.seq, m_tdata[FACE_W-1:0], due.face));
        if (m_tdata[M_DATA_W-1:FACE_W] !== '0)
          report_mismatch($sformatf("sample %0d: pad bits %b", due.seq,
                                    m_tdata[M_DATA_W-1:FACE_W]));
      end
    end
  end

  // result side back-pressure: m_tready drops at random, with a chance of 7 in 100, never while steady
  always @(negedge clk) begin
    if (rst)
      m_tready <= 1'b0;
    else
      m_tready <= steady || ($urandom_range(0, 99) >= 7);
  end

  // watchdog: cycles in which neither side accepts an item
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic [FACE_W-1:0]  aim;

    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    cfg_we       = 1'b0;
    cfg_index    = REG_UNIT_G;
    cfg_data     = '0;
    steady       = 1'b0;
    face_errors  = 0;
    sample_seq   = 0;
    unit_g_q     = UNIT_G_RST;
    thresh_q     = THRESHOLD_RST;
    held_face    = FACE_UNKNOWN;

    // reset registers: g = 4096, t = 1638, so the match limit is 2458
    directed_rows = '{
      // unknown face holds on free fall and right on the zero window
      '{0, 0, 0, 1'b1, FACE_UNKNOWN},
      '{1000, -1638, 1638, 1'b1, FACE_UNKNOWN},
      // each face straight on
      '{-4096, 0, 0, 1'b1, FACE_NX},
      '{-3000, 1000, -1000, 1'b0, FACE_UNKNOWN},
      '{0, 0, 4096, 1'b1, FACE_PZ},
      '{0, 4096, 0, 1'b1, FACE_PY},
      '{0, -4096, 0, 1'b1, FACE_NY},
      '{0, 0, -4096, 1'b1, FACE_NZ},
      '{4096, 0, 0, 1'b1, FACE_PX},
      // full-scale corners match nothing, old face stays
      '{32767, 32767, 32767, 1'b1, FACE_PX},
      '{-32768, -32768, -32768, 1'b1, FACE_PX},
      '{0, 0, 0, 1'b1, FACE_PX},
      // window and limit edges
      '{2458, 1638, -1638, 1'b0, FACE_UNKNOWN},
      '{2457, 0, 0, 1'b0, FACE_UNKNOWN},
      '{0, 2458, 0, 1'b0, FACE_UNKNOWN},
      // two faces match, the lower numbered wins
      '{-2000, 2000, 0, 1'b1, FACE_NX},
      '{-32768, 32767, -32768, 1'b0, FACE_UNKNOWN},
      '{32767, -32768, 32767, 1'b0, FACE_UNKNOWN},
      '{-1, -1, -1, 1'b0, FACE_UNKNOWN}
    };

    // extremes, threshold at or over unit_g, unit_g of zero, then random points
    cal_points = '{
      '{1, 0}, '{16383, 16383}, '{16383, 0}, '{1000, 1500}, '{0, 0},
      '{0, 16383}, '{8192, 3276}, '{4096, 1638}, '{0, 0}, '{0, 0}
    };
    for (int p = 8; p < 10; p++) begin
      cal_points[p].g = $urandom_range(1, 16383);
      cal_points[p].t = $urandom_range(0, cal_points[p].g);
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      send_sample(16'(directed_rows[i].x), 16'(directed_rows[i].y), 16'(directed_rows[i].z),
                  directed_rows[i].typed, directed_rows[i].face);
    drain();

    for (int p = 0; p < 10; p++) begin
      load_cal(cal_points[p].g, cal_points[p].t);
      // one whole phase with no idling anywhere
      steady = (p == 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 20) begin
          ax = 16'($urandom);
          ay = 16'($urandom);
          az = 16'($urandom);
        end else begin
          // aim at a face (or at zero g) with noise around its window
          aim = FACE_W'($urandom_range(FACE_UNKNOWN, FACE_PX));
          ax = axis_sample(face_dir(aim, AXIS_X));
          ay = axis_sample(face_dir(aim, AXIS_Y));
          az = axis_sample(face_dir(aim, AXIS_Z));
        end
        send_sample(ax, ay, az, 1'b0, FACE_UNKNOWN);
      end
      drain();
    end
    steady = 1'b0;

    if (face_errors == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

// ===== six_face_orientation_hysteresis_core.f =====
+incdir+design
design/sfoh_pkg.sv
design/six_face_orientation_hysteresis_core.sv
sim/tb.sv
